>>> sv/gbpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbpr_pkg: shared types and constants of the glyph bitmap pixel renderer
// Holds the input and job records, the operation, command and register codes,
// the reset values of the configuration registers and the tail width helper.
// ----------------------------------------------------------------------------
package gbpr_pkg;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration reset values
  localparam logic [15:0] TEXT_COLOR_RST  = 16'hFFFF;
  localparam logic [15:0] BACK_COLOR_RST  = 16'h0000;
  localparam logic [7:0]  FONT_HEIGHT_RST = 8'd16;

  // Pixels in a full bitmap byte
  localparam logic [3:0]  FULL_BYTE_BITS  = 4'd8;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_t;

  typedef enum logic {
    CMD_CURSOR = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TEXT_COLOR  = 2'd0,
    REG_BACK_COLOR  = 2'd1,
    REG_FONT_HEIGHT = 2'd2
  } reg_idx_t;

  // Unpacked input word
  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic        transparent;
    logic [7:0]  bitmap_byte;
  } in_item_t;

  // One classified bitmap byte, ready for the back end
  typedef struct packed {
    logic        first;     // opens a row: cursor to the row start first
    logic [15:0] left_x;
    logic [15:0] row_y;
    logic [15:0] start_x;   // column just past the cursor before the pixels
    logic [7:0]  pix;
    logic [3:0]  bits;      // pixels to emit, 1..8
    logic        skip;      // transparent clear pixels
  } job_t;

  // Pixels in the last byte of a row
  function automatic logic [3:0] tail_bits(input logic [7:0] width);
    logic [3:0] res;
    if (width[2:0] == 3'd0) begin
      res = FULL_BYTE_BITS;
    end else begin
      res = {1'b0, width[2:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/gbpr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbpr_queue: job queue between front and back
// Small register queue; front pushes classified bytes, back pops them.
// ----------------------------------------------------------------------------
module gbpr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  gbpr_pkg::job_t     push_job,
  output logic               full,
  input  wire logic          pop,
  output gbpr_pkg::job_t     pop_job,
  output logic               empty
);
  import gbpr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> sv/gbpr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbpr_front: glyph tracker and byte classifier
// Latches start words, walks rows and bytes of the glyph and turns each
// bitmap byte into a job with its row position and pixel count.
// ----------------------------------------------------------------------------
module gbpr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  gbpr_pkg::op_t          in_op,
  input  gbpr_pkg::in_item_t     in_item,
  input  wire logic [7:0]        font_height,
  output logic                   push,
  output gbpr_pkg::job_t         push_job,
  input  wire logic              full
);
  import gbpr_pkg::*;

  logic        active_r, active_nxt;
  logic [15:0] left_x_r, left_x_nxt;
  logic [15:0] top_y_r, top_y_nxt;
  logic [7:0]  width_r, width_nxt;
  logic [7:0]  height_r, height_nxt;
  logic        skip_r, skip_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [4:0]  col_byte_r, col_byte_nxt;
  logic [15:0] next_x_r, next_x_nxt;

  logic        acc;
  logic [8:0]  width_up;
  logic [5:0]  nbytes;
  logic        last_byte;
  logic        first;
  logic [15:0] row_y;
  logic [15:0] start_x;
  logic [3:0]  bits;
  logic [7:0]  row_inc;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  // Classify the incoming byte against the current glyph position
  always_comb begin
    width_up  = {1'b0, width_r} + 9'd7;
    nbytes    = width_up[8:3];
    last_byte = (({1'b0, col_byte_r} + 6'd1) >= nbytes);
    first     = (col_byte_r == 5'd0);
    row_y     = top_y_r + {8'd0, font_height} - 16'd1 - {8'd0, row_r};
    start_x   = first ? (left_x_r + 16'd1) : next_x_r;
    bits      = last_byte ? tail_bits(width_r) : FULL_BYTE_BITS;
    row_inc   = row_r + 8'd1;
  end

  assign push             = acc && (in_op == OP_BYTE) && active_r;
  assign push_job.first   = first;
  assign push_job.left_x  = left_x_r;
  assign push_job.row_y   = row_y;
  assign push_job.start_x = start_x;
  assign push_job.pix     = in_item.bitmap_byte;
  assign push_job.bits    = bits;
  assign push_job.skip    = skip_r;

  // Latch a glyph on start, advance through it on each byte
  always_comb begin
    active_nxt   = active_r;
    left_x_nxt   = left_x_r;
    top_y_nxt    = top_y_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    skip_nxt     = skip_r;
    row_nxt      = row_r;
    col_byte_nxt = col_byte_r;
    next_x_nxt   = next_x_r;
    if (acc && (in_op == OP_START)) begin
      left_x_nxt   = in_item.origin_x;
      top_y_nxt    = in_item.origin_y;
      width_nxt    = in_item.glyph_width;
      height_nxt   = in_item.glyph_height;
      skip_nxt     = in_item.transparent;
      row_nxt      = 8'd0;
      col_byte_nxt = 5'd0;
      next_x_nxt   = 16'd0;
      active_nxt   = (in_item.glyph_width != 8'd0) && (in_item.glyph_height != 8'd0);
    end else if (push) begin
      if (in_item.bitmap_byte == 8'd0) begin
        next_x_nxt = start_x + 16'd8;
      end else begin
        next_x_nxt = start_x + {12'd0, bits};
      end
      if (last_byte) begin
        col_byte_nxt = 5'd0;
        row_nxt      = row_inc;
        if (row_inc >= height_r) begin
          active_nxt = 1'b0;
        end
      end else begin
        col_byte_nxt = col_byte_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      left_x_r   <= '0;
      top_y_r    <= '0;
      width_r    <= '0;
      height_r   <= '0;
      skip_r     <= 1'b0;
      row_r      <= '0;
      col_byte_r <= '0;
      next_x_r   <= '0;
    end else begin
      active_r   <= active_nxt;
      left_x_r   <= left_x_nxt;
      top_y_r    <= top_y_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      skip_r     <= skip_nxt;
      row_r      <= row_nxt;
      col_byte_r <= col_byte_nxt;
      next_x_r   <= next_x_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/gbpr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbpr_back: command sequencer
// Pops jobs and issues one display command per cycle into the output
// register while it is empty or taken: the row cursor for a row's first byte,
// then a skip for an empty byte or one command per pixel.
// ----------------------------------------------------------------------------
module gbpr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  gbpr_pkg::job_t      pop_job,
  input  wire logic           empty,
  output logic                pop,
  input  wire logic [15:0]    text_color,
  input  wire logic [15:0]    back_color,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gbpr_pkg::cmd_t      out_cmd,
  output logic [15:0]         out_x,
  output logic [15:0]         out_y,
  output logic [15:0]         out_color,
  output logic                out_last
);
  import gbpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CURSOR = 3'b010,
    ST_PIXEL  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] left_x_r, left_x_nxt;
  logic [15:0] row_y_r, row_y_nxt;
  logic [15:0] cur_x_r, cur_x_nxt;
  logic [7:0]  pix_r, pix_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;
  logic        zero_r, zero_nxt;

  logic        valid_r, valid_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [15:0] color_r, color_nxt;
  logic        last_r, last_nxt;

  logic        slot_free;
  logic        emit;
  logic        done;
  logic        load;
  cmd_t        e_cmd;
  logic [15:0] e_x, e_y, e_color;
  logic        e_last;

  assign slot_free = !valid_r || out_ready;

  // Sequence commands for the current job and fetch the next one
  always_comb begin
    state_nxt  = state_r;
    left_x_nxt = left_x_r;
    row_y_nxt  = row_y_r;
    cur_x_nxt  = cur_x_r;
    pix_nxt    = pix_r;
    cnt_nxt    = cnt_r;
    skip_nxt   = skip_r;
    zero_nxt   = zero_r;
    emit       = 1'b0;
    done       = 1'b0;
    load       = 1'b0;
    e_cmd      = CMD_CURSOR;
    e_x        = 16'd0;
    e_y        = 16'd0;
    e_color    = 16'd0;
    e_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        load = !empty;
      end
      ST_CURSOR: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_cmd     = CMD_CURSOR;
          e_x       = left_x_r;
          e_y       = row_y_r;
          state_nxt = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (slot_free) begin
          emit = 1'b1;
          if (zero_r) begin
            e_cmd  = CMD_CURSOR;
            e_x    = cur_x_r + 16'd7;
            e_y    = row_y_r;
            e_last = 1'b1;
            done   = 1'b1;
          end else begin
            if (pix_r[7]) begin
              e_cmd   = CMD_PIXEL;
              e_color = text_color;
            end else if (skip_r) begin
              e_cmd = CMD_CURSOR;
              e_x   = cur_x_r;
              e_y   = row_y_r;
            end else begin
              e_cmd   = CMD_PIXEL;
              e_color = back_color;
            end
            e_last    = (cnt_r == 4'd1);
            done      = (cnt_r == 4'd1);
            cur_x_nxt = cur_x_r + 16'd1;
            pix_nxt   = {pix_r[6:0], 1'b0};
            cnt_nxt   = cnt_r - 4'd1;
          end
          if (done) begin
            load      = !empty;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      left_x_nxt = pop_job.left_x;
      row_y_nxt  = pop_job.row_y;
      cur_x_nxt  = pop_job.start_x;
      pix_nxt    = pop_job.pix;
      cnt_nxt    = pop_job.bits;
      skip_nxt   = pop_job.skip;
      zero_nxt   = (pop_job.pix == 8'd0);
      state_nxt  = pop_job.first ? ST_CURSOR : ST_PIXEL;
    end
  end

  assign pop = load;

  // Output register: refill whenever it is empty or taken
  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    color_nxt = color_r;
    last_nxt  = last_r;
    if (slot_free) begin
      valid_nxt = emit;
      cmd_nxt   = e_cmd;
      x_nxt     = e_x;
      y_nxt     = e_y;
      color_nxt = e_color;
      last_nxt  = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_x_r <= left_x_nxt;
    row_y_r  <= row_y_nxt;
    cur_x_r  <= cur_x_nxt;
    pix_r    <= pix_nxt;
    cnt_r    <= cnt_nxt;
    skip_r   <= skip_nxt;
    zero_r   <= zero_nxt;
    cmd_r    <= cmd_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    color_r  <= color_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_cmd   = cmd_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_color = color_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

>>> sv/glyph_bitmap_pixel_renderer.sv
`default_nettype none
// Path: a start word yields no commands; a bitmap byte passes through the
//   queue slot, the back-end job registers and the output register.
// Throughput: one command per cycle from the back-end sequencer when not stalled
//   by out_tready; a byte gives an optional row cursor and one command per pixel, or a single skip.
// Reset: synchronous, active low; clears glyph state, queue and output valid,
//   and returns the color and font height registers to their reset values.
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_renderer: 1 bpp glyph to display command expander
// Front end tracks the glyph and classifies bytes, a short queue decouples it
// from the back end, which issues cursor and pixel commands one per cycle unless stalled.
// ----------------------------------------------------------------------------
module glyph_bitmap_pixel_renderer #(
  parameter int QUEUE_DEPTH = gbpr_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] origin_x, [31:16] origin_y, [39:32] glyph_width,
  // [47:40] glyph_height, [48] transparent, [56:49] bitmap_byte, [63:57] zero
  input  wire logic [63:0] in_tdata,
  // [0] operation
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] color
  output logic [47:0]      out_tdata,
  // [0] command
  output logic             out_tuser,
  output logic             out_tlast,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import gbpr_pkg::*;

  logic [15:0] text_color_r, text_color_nxt;
  logic [15:0] back_color_r, back_color_nxt;
  logic [7:0]  font_height_r, font_height_nxt;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  in_item_t    item;
  op_t         op;
  logic        push, full, pop, empty;
  job_t        push_job, pop_job;
  cmd_t        out_cmd;
  logic [15:0] out_x, out_y, out_color;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    text_color_nxt  = text_color_r;
    back_color_nxt  = back_color_r;
    font_height_nxt = font_height_r;
    cfg_prdata      = 32'd0;
    unique case (cfg_idx)
      REG_TEXT_COLOR: begin
        cfg_prdata = {16'd0, text_color_r};
        if (cfg_wr) begin
          text_color_nxt = cfg_pwdata[15:0];
        end
      end
      REG_BACK_COLOR: begin
        cfg_prdata = {16'd0, back_color_r};
        if (cfg_wr) begin
          back_color_nxt = cfg_pwdata[15:0];
        end
      end
      REG_FONT_HEIGHT: begin
        cfg_prdata = {24'd0, font_height_r};
        if (cfg_wr) begin
          font_height_nxt = cfg_pwdata[7:0];
        end
      end
      default: begin
        cfg_prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= TEXT_COLOR_RST;
      back_color_r  <= BACK_COLOR_RST;
      font_height_r <= FONT_HEIGHT_RST;
    end else begin
      text_color_r  <= text_color_nxt;
      back_color_r  <= back_color_nxt;
      font_height_r <= font_height_nxt;
    end
  end

  // Unpack the input word
  assign op                = op_t'(in_tuser);
  assign item.origin_x     = in_tdata[15:0];
  assign item.origin_y     = in_tdata[31:16];
  assign item.glyph_width  = in_tdata[39:32];
  assign item.glyph_height = in_tdata[47:40];
  assign item.transparent  = in_tdata[48];
  assign item.bitmap_byte  = in_tdata[56:49];

  gbpr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (op),
    .in_item     (item),
    .font_height (font_height_r),
    .push        (push),
    .push_job    (push_job),
    .full        (full)
  );

  gbpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  gbpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_job    (pop_job),
    .empty      (empty),
    .pop        (pop),
    .text_color (text_color_r),
    .back_color (back_color_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cmd    (out_cmd),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_color  (out_color),
    .out_last   (out_tlast)
  );

  // Pack the result word
  assign out_tdata = {out_color, out_y, out_x};
  assign out_tuser = out_cmd;

endmodule
`default_nettype wire
